### sv/rlc_pkg.sv
package rlc_pkg;

    // Storage depth and derived index widths
    localparam int MAX_DEPTH = 16;
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FILL_W    = $clog2(MAX_DEPTH + 1);

    // Field widths
    localparam int ID_W  = 32;
    localparam int CNT_W = 16;
    localparam int CFG_W = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX         = '1;
    localparam logic [CFG_W-1:0] RESET_MAX_ENTRIES = 5'd5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LIST  = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming request
        logic find;        // latch the lookup result
        logic update;      // commit add or clear to the list
        logic out_load;    // load the output register
        logic list_emit;   // output register takes the current list entry
        logic list_start;  // point the read index at the newest entry
        logic list_next;   // step the read index toward the oldest entry
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    fill_zero;
        logic    rd_last;
    } status_t;

endpackage

### sv/rlc_ctrl.sv
module rlc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    output logic              m_tvalid,
    input  rlc_pkg::status_t  status,
    output rlc_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_EXEC,
        ST_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Sequence one request through lookup, execute and list walk
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FIND;
                end
            end
            ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    if (status.op == rlc_pkg::OP_LIST && !status.fill_zero)
                    begin
                        cmd.list_start = 1'b1;
                        state_next     = ST_LIST;
                    end
                    else
                    begin
                        cmd.update   = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.list_emit = 1'b1;
                    cmd.list_next = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output valid until the result is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### sv/rlc_datapath.sv
module rlc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [rlc_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                        in_opcode,
    input  logic [rlc_pkg::ID_W-1:0]          in_app_id,
    input  rlc_pkg::cmd_t                     cmd,
    output rlc_pkg::status_t                  status,
    output logic [rlc_pkg::ID_W-1:0]          out_entry_id,
    output logic [rlc_pkg::CNT_W-1:0]         out_start_count,
    output logic                              out_present,
    output logic                              out_evicted,
    output logic [rlc_pkg::ID_W-1:0]          out_evicted_id,
    output logic                              out_last
);

    localparam int MD = rlc_pkg::MAX_DEPTH;
    localparam int IW = rlc_pkg::IDX_W;
    localparam int FW = rlc_pkg::FILL_W;
    localparam int DW = rlc_pkg::ID_W;
    localparam int CW = rlc_pkg::CNT_W;

    // Entry storage, oldest at index 0
    logic [DW-1:0] ids_reg  [MD];
    logic [CW-1:0] cnts_reg [MD];
    logic [DW-1:0] ids_next [MD];
    logic [CW-1:0] cnts_next[MD];

    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;
    logic [rlc_pkg::CFG_W-1:0]   max_reg;
    rlc_pkg::opcode_t            op_reg;
    logic [DW-1:0]               id_reg;
    logic                        hit_reg;
    logic [IW-1:0]               rd_idx_reg;
    logic [IW-1:0]               rd_idx_next;

    logic [DW-1:0] out_id_reg;
    logic [CW-1:0] out_cnt_reg;
    logic          out_pres_reg;
    logic          out_ev_reg;
    logic [DW-1:0] out_evid_reg;
    logic          out_last_reg;

    logic          hit;
    logic [IW-1:0] hit_idx;
    logic [DW-1:0] rd_id;
    logic [CW-1:0] rd_cnt;

    logic          full;
    logic          rm;
    logic [IW-1:0] rm_idx;
    logic          ev_first;
    logic          ev_second;
    logic [FW-1:0] mid_fill;
    logic [FW-1:0] lim;
    logic [CW-1:0] new_cnt;
    logic [DW-1:0] mid_ids [MD];
    logic [CW-1:0] mid_cnts[MD];
    logic [DW-1:0] evid;
    logic [FW-1:0] fill_add;

    // Parallel compare against the valid entries, lowest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MD - 1; i >= 0; i--)
        begin
            if (FW'(i) < fill_reg && ids_reg[i] == id_reg)
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // Single read port
    assign rd_id  = ids_reg[rd_idx_reg];
    assign rd_cnt = cnts_reg[rd_idx_reg];

    // Effective limit: zero acts as one, clamp to the depth
    always_comb
    begin
        if (max_reg == '0)
        begin
            lim = FW'(1);
        end
        else if (32'(max_reg) > MD)
        begin
            lim = FW'(MD);
        end
        else
        begin
            lim = FW'(max_reg);
        end
    end

    // Add: drop the hit (or the oldest when full), append, then trim to limit
    assign full     = (fill_reg == FW'(MD));
    assign rm       = hit_reg || full;
    assign rm_idx   = hit_reg ? rd_idx_reg : '0;
    assign ev_first = !hit_reg && full;
    assign mid_fill = fill_reg - FW'(rm) + FW'(1);
    assign ev_second = !ev_first && (mid_fill > lim);
    assign fill_add = mid_fill - FW'(ev_second);

    always_comb
    begin
        if (!hit_reg)
        begin
            new_cnt = CW'(1);
        end
        else if (rd_cnt == rlc_pkg::COUNT_MAX)
        begin
            new_cnt = rd_cnt;
        end
        else
        begin
            new_cnt = rd_cnt + CW'(1);
        end
    end

    always_comb
    begin
        for (int k = 0; k < MD; k++)
        begin
            if (FW'(k) == mid_fill - FW'(1))
            begin
                mid_ids[k]  = id_reg;
                mid_cnts[k] = new_cnt;
            end
            else if (rm && IW'(k) >= rm_idx)
            begin
                mid_ids[k]  = ids_reg[(k + 1 < MD) ? k + 1 : k];
                mid_cnts[k] = cnts_reg[(k + 1 < MD) ? k + 1 : k];
            end
            else
            begin
                mid_ids[k]  = ids_reg[k];
                mid_cnts[k] = cnts_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MD; i++)
        begin
            if (ev_second)
            begin
                ids_next[i]  = mid_ids[(i + 1 < MD) ? i + 1 : i];
                cnts_next[i] = mid_cnts[(i + 1 < MD) ? i + 1 : i];
            end
            else
            begin
                ids_next[i]  = mid_ids[i];
                cnts_next[i] = mid_cnts[i];
            end
        end
    end

    always_comb
    begin
        if (ev_first)
        begin
            evid = ids_reg[0];
        end
        else if (ev_second)
        begin
            evid = mid_ids[0];
        end
        else
        begin
            evid = '0;
        end
    end

    // Fill level after an update
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.update)
        begin
            case (op_reg)
                rlc_pkg::OP_ADD:   fill_next = fill_add;
                rlc_pkg::OP_CLEAR: fill_next = '0;
                default:           fill_next = fill_reg;
            endcase
        end
    end

    // Read index: lookup hit, newest entry, then step down
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.find)
        begin
            rd_idx_next = hit_idx;
        end
        else if (cmd.list_start)
        begin
            rd_idx_next = IW'(fill_reg - FW'(1));
        end
        else if (cmd.list_next)
        begin
            rd_idx_next = rd_idx_reg - IW'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            max_reg  <= rlc_pkg::RESET_MAX_ENTRIES;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Request, lookup and entry storage
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= rlc_pkg::opcode_t'(in_opcode);
            id_reg <= in_app_id;
        end
        if (cmd.find)
        begin
            hit_reg <= hit;
        end
        rd_idx_reg <= rd_idx_next;
        if (cmd.update && op_reg == rlc_pkg::OP_ADD)
        begin
            for (int i = 0; i < MD; i++)
            begin
                ids_reg[i]  <= ids_next[i];
                cnts_reg[i] <= cnts_next[i];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.list_emit)
            begin
                out_id_reg   <= rd_id;
                out_cnt_reg  <= rd_cnt;
                out_pres_reg <= 1'b1;
                out_ev_reg   <= 1'b0;
                out_evid_reg <= '0;
                out_last_reg <= (rd_idx_reg == '0);
            end
            else
            begin
                out_last_reg <= 1'b1;
                case (op_reg)
                    rlc_pkg::OP_ADD:
                    begin
                        out_id_reg   <= id_reg;
                        out_cnt_reg  <= new_cnt;
                        out_pres_reg <= 1'b1;
                        out_ev_reg   <= ev_first || ev_second;
                        out_evid_reg <= evid;
                    end
                    rlc_pkg::OP_QUERY:
                    begin
                        out_id_reg   <= id_reg;
                        out_cnt_reg  <= hit_reg ? rd_cnt : '0;
                        out_pres_reg <= hit_reg;
                        out_ev_reg   <= 1'b0;
                        out_evid_reg <= '0;
                    end
                    default:
                    begin
                        out_id_reg   <= '0;
                        out_cnt_reg  <= '0;
                        out_pres_reg <= 1'b0;
                        out_ev_reg   <= 1'b0;
                        out_evid_reg <= '0;
                    end
                endcase
            end
        end
    end

    assign status.op        = op_reg;
    assign status.fill_zero = (fill_reg == '0);
    assign status.rd_last   = (rd_idx_reg == '0);

    assign out_entry_id    = out_id_reg;
    assign out_start_count = out_cnt_reg;
    assign out_present     = out_pres_reg;
    assign out_evicted     = out_ev_reg;
    assign out_evicted_id  = out_evid_reg;
    assign out_last        = out_last_reg;

endmodule

### sv/recency_list_with_counts.sv
// Add, clear and query: capture, lookup, execute; the result loads once the output is free.
// The sequencer takes a new request only when idle, after its lookup and execute steps.
// List: the walk reads one entry a cycle through the read port while the output is free.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous): list empty, limit 5, output invalid; entries not cleared.
module recency_list_with_counts (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // [4:0] max_entries
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] app_id
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [31:0] entry_id, [47:32] start_count, [79:48] evicted_id
    output logic [1:0]  m_tuser,    // [0] present, [1] evicted
    output logic        m_tlast
);

    rlc_pkg::cmd_t    cmd;
    rlc_pkg::status_t status;

    logic [rlc_pkg::ID_W-1:0]  entry_id;
    logic [rlc_pkg::CNT_W-1:0] start_count;
    logic                      present;
    logic                      evicted;
    logic [rlc_pkg::ID_W-1:0]  evicted_id;
    logic                      last;

    assign cfg_ready = 1'b1;

    rlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    rlc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .in_opcode       (s_tuser),
        .in_app_id       (s_tdata),
        .cmd             (cmd),
        .status          (status),
        .out_entry_id    (entry_id),
        .out_start_count (start_count),
        .out_present     (present),
        .out_evicted     (evicted),
        .out_evicted_id  (evicted_id),
        .out_last        (last)
    );

    // Pack the result fields
    assign m_tdata = {evicted_id, start_count, entry_id};
    assign m_tuser = {evicted, present};
    assign m_tlast = last;

endmodule
